FILE: sv/hhm_pkg.sv
// ----------------------------------------------------------------------------
// hhm_pkg: shared types and constants of the HSV / heat-map color mapper
// Field widths, fixed-point constants, operation codes and the structs
// passed between the heat-hue divider and the HSV pipeline.
// ----------------------------------------------------------------------------
package hhm_pkg;

	localparam int HUE_W   = 16;              // Q0.16 hue
	localparam int CHAN_W  = 17;              // Q1.16 saturation / value
	localparam int FORCE_W = 32;              // Q16.16 force
	localparam int COLOR_W = 8;               // output channel
	localparam int QUO_W   = HUE_W;           // heat hue quotient bits
	localparam int DIV_W   = FORCE_W + 5;     // 20 * full scale
	localparam int REM_W   = DIV_W;           // divider remainder

	localparam int HEAT_NUM = 13;             // 0.65 = 13 / 20
	localparam int HEAT_DEN = 20;
	localparam int CH_MAX   = 255;

	localparam logic [CHAN_W-1:0]  ONE_Q16        = CHAN_W'(65536);
	localparam logic [FORCE_W-1:0] FULL_SCALE_RST = FORCE_W'(65536);

	typedef enum logic {
		OP_HSV  = 1'b0,
		OP_HEAT = 1'b1
	} op_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] sat;
		logic [CHAN_W-1:0] val;
	} hsv_t;

	// Sideband carried alongside the divider
	typedef struct packed {
		op_t  op;
		logic hot;
		hsv_t hsv;
	} side_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

endpackage

FILE: sv/hhm_heat.sv
// ----------------------------------------------------------------------------
// hhm_heat: heat-map hue stage
// Maps a force magnitude to the hue (1 - F/M) * 0.65 through a pipelined
// restoring divider, one quotient bit per stage. HSV requests ride along.
// ----------------------------------------------------------------------------
module hhm_heat import hhm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  op_t                in_op,
	input  hsv_t               in_hsv,
	input  logic [FORCE_W-1:0] force_magnitude,
	input  logic [FORCE_W-1:0] full_scale,
	input  logic [DIV_W-1:0]   divisor,
	output logic               out_valid,
	output hsv_t               out_hsv
);

	logic               v_s1;
	side_t              side_s1;
	logic [FORCE_W-1:0] diff_s1;

	logic               v_sd    [0:QUO_W];
	side_t              side_sd [0:QUO_W];
	logic [REM_W-1:0]   rem_sd  [0:QUO_W];
	logic [QUO_W-1:0]   quo_sd  [0:QUO_W];

	// Stage 1: distance to full scale, saturation test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.op  <= in_op;
			side_s1.hot <= force_magnitude >= full_scale;
			side_s1.hsv <= in_hsv;
			diff_s1     <= full_scale - force_magnitude;
		end
	end

	// Stage 2: dividend (M - F) * 13, held below 20 * M
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (adv) begin
			v_sd[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_sd[0] <= side_s1;
			quo_sd[0]  <= '0;
			if (side_s1.hot || side_s1.op == OP_HSV) begin
				rem_sd[0] <= '0;
			end else begin
				rem_sd[0] <= REM_W'(diff_s1) * REM_W'(HEAT_NUM);
			end
		end
	end

	// One quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [REM_W:0] dbl;
		logic           fits;

		assign dbl  = {rem_sd[k], 1'b0};
		assign fits = dbl >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (adv) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_sd[k+1] <= side_sd[k];
				quo_sd[k+1]  <= {quo_sd[k][QUO_W-2:0], fits};
				if (fits) begin
					rem_sd[k+1] <= REM_W'(dbl - {1'b0, divisor});
				end else begin
					rem_sd[k+1] <= REM_W'(dbl);
				end
			end
		end
	end

	assign out_valid = v_sd[QUO_W];

	// Heat requests take the quotient as hue at full saturation and value
	always_comb begin
		out_hsv = side_sd[QUO_W].hsv;
		if (side_sd[QUO_W].op == OP_HEAT) begin
			out_hsv.hue = side_sd[QUO_W].hot ? '0 : quo_sd[QUO_W];
			out_hsv.sat = ONE_Q16;
			out_hsv.val = ONE_Q16;
		end
	end

endmodule

FILE: sv/hhm_hsv.sv
// ----------------------------------------------------------------------------
// hhm_hsv: six-sector HSV to RGB pipeline
// Five register stages: sector split, factor products, complements,
// value products, scale by 255 and channel select.
// ----------------------------------------------------------------------------
module hhm_hsv import hhm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  hsv_t in_hsv,
	output logic out_valid,
	output rgb_t out_rgb
);

	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	localparam int H6_W  = HUE_W + 3;          // 6 * hue
	localparam int PW    = 2 * HUE_W + 1;      // products up to 2^32
	localparam int VW    = CHAN_W + COLOR_W;   // 255 * v
	localparam int CPW   = PW + COLOR_W;       // 255 * v * (1 - s)
	localparam int QW    = CHAN_W + PW - 1;    // v * factor, up to 2^48
	localparam int QQW   = QW + COLOR_W;       // 255 * v * factor

	localparam logic [PW-1:0] FULL_Q32 = {1'b1, {(PW-1){1'b0}}};

	// Stage 1
	logic [H6_W-1:0]   h6;
	logic [CHAN_W-1:0] sat_c;
	logic [CHAN_W-1:0] val_c;
	logic              v_s1;
	sector_t           sector_s1;
	logic [HUE_W-1:0]  frac_s1;
	logic [CHAN_W-1:0] sat_s1;
	logic [CHAN_W-1:0] val_s1;

	assign h6    = H6_W'(in_hsv.hue) * H6_W'(6);
	assign sat_c = (in_hsv.sat > ONE_Q16) ? ONE_Q16 : in_hsv.sat;
	assign val_c = (in_hsv.val > ONE_Q16) ? ONE_Q16 : in_hsv.val;

	// Stage 2
	logic [CHAN_W-1:0]  frac_inv;
	logic [VW-1:0]      vprod;
	logic               v_s2;
	sector_t            sector_s2;
	logic [CHAN_W-1:0]  val_s2;
	logic [PW-1:0]      fs_s2;
	logic [PW-1:0]      f1s_s2;
	logic [PW-1:0]      vs_s2;
	logic [COLOR_W-1:0] cv_s2;

	assign frac_inv = ONE_Q16 - CHAN_W'(frac_s1);
	assign vprod    = VW'(val_s1) * VW'(CH_MAX);

	// Stage 3
	logic [CPW-1:0]     cpprod;
	logic               v_s3;
	sector_t            sector_s3;
	logic [CHAN_W-1:0]  val_s3;
	logic [PW-1:0]      fq_s3;
	logic [PW-1:0]      ft_s3;
	logic [COLOR_W-1:0] cp_s3;
	logic [COLOR_W-1:0] cv_s3;

	assign cpprod = CPW'(vs_s2) * CPW'(CH_MAX);

	// Stage 4
	logic               v_s4;
	sector_t            sector_s4;
	logic [QW-1:0]      pq_s4;
	logic [QW-1:0]      pt_s4;
	logic [COLOR_W-1:0] cp_s4;
	logic [COLOR_W-1:0] cv_s4;

	// Stage 5
	logic [QQW-1:0]     cqprod;
	logic [QQW-1:0]     ctprod;
	logic [COLOR_W-1:0] cq;
	logic [COLOR_W-1:0] ct;
	rgb_t               rgb;
	logic               v_s5;
	rgb_t               rgb_s5;

	assign cqprod = QQW'(pq_s4) * QQW'(CH_MAX);
	assign ctprod = QQW'(pt_s4) * QQW'(CH_MAX);
	assign cq     = cqprod[3*HUE_W+COLOR_W-1:3*HUE_W];
	assign ct     = ctprod[3*HUE_W+COLOR_W-1:3*HUE_W];

	always_comb begin
		unique case (sector_s4)
			SEC_RED_YELLOW:   rgb = '{red: cv_s4, green: ct,    blue: cp_s4};
			SEC_YELLOW_GREEN: rgb = '{red: cq,    green: cv_s4, blue: cp_s4};
			SEC_GREEN_CYAN:   rgb = '{red: cp_s4, green: cv_s4, blue: ct};
			SEC_CYAN_BLUE:    rgb = '{red: cp_s4, green: cq,    blue: cv_s4};
			SEC_BLUE_MAGENTA: rgb = '{red: ct,    green: cp_s4, blue: cv_s4};
			default:          rgb = '{red: cv_s4, green: cp_s4, blue: cq};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= sector_t'(h6[H6_W-1:HUE_W]);
			frac_s1   <= h6[HUE_W-1:0];
			sat_s1    <= sat_c;
			val_s1    <= val_c;

			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			fs_s2     <= PW'(frac_s1) * PW'(sat_s1);
			f1s_s2    <= PW'(frac_inv) * PW'(sat_s1);
			vs_s2     <= PW'(val_s1) * PW'(ONE_Q16 - sat_s1);
			cv_s2     <= vprod[HUE_W+COLOR_W-1:HUE_W];

			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			fq_s3     <= FULL_Q32 - fs_s2;
			ft_s3     <= FULL_Q32 - f1s_s2;
			cp_s3     <= cpprod[2*HUE_W+COLOR_W-1:2*HUE_W];
			cv_s3     <= cv_s2;

			sector_s4 <= sector_s3;
			pq_s4     <= QW'(val_s3) * QW'(fq_s3);
			pt_s4     <= QW'(val_s3) * QW'(ft_s3);
			cp_s4     <= cp_s3;
			cv_s4     <= cv_s3;

			rgb_s5    <= rgb;
		end
	end

	assign out_valid = v_s5;
	assign out_rgb   = rgb_s5;

endmodule

FILE: sv/hsv_heat_map_color.sv
// ----------------------------------------------------------------------------
// hsv_heat_map_color: HSV and heat-map color mapper
// Converts HSV triples, or force magnitudes through a heat-map hue, to RGB.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_ready is high and returns one RGB
// result per request, in order; req_ready is low while the spare output
// slot holds a result. The depth is set by the sixteen-stage restoring
// divider that forms the heat hue, followed by the five-stage HSV pipeline
// and the output register; HSV requests travel the same path. A two-entry
// output buffer lets the pipeline keep accepting while one result waits to
// be taken. The full scale register sits at byte address 0; 20 times its
// value is kept in a second register as the divider's divisor.
module hsv_heat_map_color import hhm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               operation,
	input  logic [HUE_W-1:0]   hue,
	input  logic [CHAN_W-1:0]  saturation,
	input  logic [CHAN_W-1:0]  brightness,
	input  logic [FORCE_W-1:0] force_magnitude,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [COLOR_W-1:0] red,
	output logic [COLOR_W-1:0] green,
	output logic [COLOR_W-1:0] blue,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic REG_FULL_SCALE = 1'b0;

	localparam logic [DIV_W-1:0] DIVISOR_RST = DIV_W'(FULL_SCALE_RST) * DIV_W'(HEAT_DEN);

	logic               cfg_wr;
	logic [FORCE_W-1:0] full_scale_q;
	logic [DIV_W-1:0]   divisor_q;

	logic               adv;
	hsv_t               req_hsv;
	logic               heat_valid;
	hsv_t               heat_hsv;
	logic               hsv_valid;
	rgb_t               hsv_rgb;

	logic               out_valid_q;
	rgb_t               out_rgb_q;
	logic               skid_valid_q;
	rgb_t               skid_rgb_q;

	// Configuration
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FULL_SCALE);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FULL_SCALE) ? full_scale_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
			divisor_q    <= DIVISOR_RST;
		end else if (cfg_wr) begin
			full_scale_q <= pwdata;
			divisor_q    <= DIV_W'(pwdata) * DIV_W'(HEAT_DEN);
		end
	end

	// Pipeline advances while the spare output slot is free
	assign adv       = !skid_valid_q;
	assign req_ready = adv;

	assign req_hsv = '{hue: hue, sat: saturation, val: brightness};

	hhm_heat u_heat (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_valid        (req_valid),
		.in_op           (op_t'(operation)),
		.in_hsv          (req_hsv),
		.force_magnitude (force_magnitude),
		.full_scale      (full_scale_q),
		.divisor         (divisor_q),
		.out_valid       (heat_valid),
		.out_hsv         (heat_hsv)
	);

	hhm_hsv u_hsv (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (heat_valid),
		.in_hsv    (heat_hsv),
		.out_valid (hsv_valid),
		.out_rgb   (hsv_rgb)
	);

	// Output register with one spare slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= adv && hsv_valid;
			end
		end else if (adv && hsv_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp_ready) begin
			out_rgb_q <= skid_valid_q ? skid_rgb_q : hsv_rgb;
		end else if (adv && hsv_valid) begin
			skid_rgb_q <= hsv_rgb;
		end
	end

	assign rsp_valid = out_valid_q;
	assign red       = out_rgb_q.red;
	assign green     = out_rgb_q.green;
	assign blue      = out_rgb_q.blue;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("spare slot holds a result while the output register is empty");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && hsv_valid) |=> out_valid_q)
		else $error("finished result dropped at the output");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
		else $error("request side stalled without a stalled result");

	a_divisor_track: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> divisor_q == DIV_W'(full_scale_q) * DIV_W'(HEAT_DEN))
		else $error("divisor out of step with full scale");

endmodule

FILE: tb/tb_hsv_heat_map_color.sv
// ----------------------------------------------------------------------------
// tb_hsv_heat_map_color: self-checking bench for the HSV / heat-map mapper
// Drives HSV and heat requests through a valid/ready channel with random
// gaps on both sides, predicts each RGB result in integer fixed point and
// compares it in order. The full-scale register is reprogrammed over APB
// between phases, including its extremes.
// ----------------------------------------------------------------------------
module tb_hsv_heat_map_color import hhm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] FULL_SCALE_ADDR = 3'd0;
	localparam logic [2:0] SPARE_ADDR      = 3'd4;
	localparam int         HOLD_OFF_CYCLES = 200;
	localparam int         DRAIN_CYCLES    = 30;

	typedef struct {
		op_t                op;
		logic [HUE_W-1:0]   hue;
		logic [CHAN_W-1:0]  sat;
		logic [CHAN_W-1:0]  val;
		logic [FORCE_W-1:0] force_mag;
	} color_req_t;

	logic               clk;
	logic               arst_n          = 1'b0;
	logic               req_valid       = 1'b0;
	logic               req_ready;
	logic               operation       = 1'b0;
	logic [HUE_W-1:0]   hue             = '0;
	logic [CHAN_W-1:0]  saturation      = '0;
	logic [CHAN_W-1:0]  brightness      = '0;
	logic [FORCE_W-1:0] force_magnitude = '0;
	logic               rsp_valid;
	logic               rsp_ready       = 1'b0;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               psel            = 1'b0;
	logic               penable         = 1'b0;
	logic               pwrite          = 1'b0;
	logic [2:0]         paddr           = '0;
	logic [31:0]        pwdata          = '0;
	logic [31:0]        prdata;
	logic               pready;

	color_req_t         pending_reqs[$];
	rgb_t               expected_colors[$];
	logic [FORCE_W-1:0] full_scale_model = FULL_SCALE_RST;
	int                 results_owed     = 0;
	int                 mismatches       = 0;
	bit                 tx_quiet         = 1'b0;
	bit                 rx_quiet         = 1'b0;
	int                 hold_off_count   = 0;
	int                 hold_off_seen    = 0;

	// driver / monitor working state
	color_req_t cur_req;
	bit         tx_next_valid;
	int         tx_gap = 0;
	int         rx_wait = 0;
	rgb_t       want_color;

	hsv_heat_map_color dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.operation       (operation),
		.hue             (hue),
		.saturation      (saturation),
		.brightness      (brightness),
		.force_magnitude (force_magnitude),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rgb_t hsv_color(input logic [HUE_W-1:0] h,
			input logic [CHAN_W-1:0] s_in, input logic [CHAN_W-1:0] v_in);
		logic [63:0] s, v, h6, f, cv, cp, cq, ct;
		rgb_t        c;
		s  = (s_in > ONE_Q16) ? 64'(ONE_Q16) : 64'(s_in);
		v  = (v_in > ONE_Q16) ? 64'(ONE_Q16) : 64'(v_in);
		h6 = 64'(h) * 64'd6;
		f  = h6 & 64'hFFFF;
		cv = (64'(CH_MAX) * v) >> 16;
		cp = (64'(CH_MAX) * v * (64'(ONE_Q16) - s)) >> 32;
		cq = (64'(CH_MAX) * v * ((64'd1 << 32) - f * s)) >> 48;
		ct = (64'(CH_MAX) * v * ((64'd1 << 32) - (64'(ONE_Q16) - f) * s)) >> 48;
		case (h6[18:16])
			3'd0: c = '{cv[7:0], ct[7:0], cp[7:0]};
			3'd1: c = '{cq[7:0], cv[7:0], cp[7:0]};
			3'd2: c = '{cp[7:0], cv[7:0], ct[7:0]};
			3'd3: c = '{cp[7:0], cq[7:0], cv[7:0]};
			3'd4: c = '{ct[7:0], cp[7:0], cv[7:0]};
			default: c = '{cv[7:0], cp[7:0], cq[7:0]};
		endcase
		return c;
	endfunction

	// (1 - F/M) * 13/20 as a Q0.16 hue, zero at or above full scale
	function automatic logic [HUE_W-1:0] heat_hue(input logic [FORCE_W-1:0] f,
			input logic [FORCE_W-1:0] m);
		logic [63:0] num;
		if (f >= m)
			return '0;
		num = 64'(m - f) * 64'(ONE_Q16) * 64'(HEAT_NUM);
		return HUE_W'(num / (64'(HEAT_DEN) * 64'(m)));
	endfunction

	function automatic rgb_t predict_color(input color_req_t r);
		if (r.op == OP_HEAT)
			return hsv_color(heat_hue(r.force_mag, full_scale_model), ONE_Q16, ONE_Q16);
		return hsv_color(r.hue, r.sat, r.val);
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return CHAN_W'($urandom_range(0, 131071));
			1: return ONE_Q16;
			default: return CHAN_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic color_req_t rand_req(input logic [FORCE_W-1:0] scale);
		color_req_t r;
		r.op  = op_t'($urandom_range(0, 1));
		r.hue = HUE_W'($urandom);
		r.sat = rand_chan();
		r.val = rand_chan();
		case ($urandom_range(0, 3))
			0: r.force_mag = $urandom;
			1: r.force_mag = $urandom_range(0, scale);
			2: r.force_mag = scale + $urandom_range(0, 4) - 32'd2;
			default: r.force_mag = $urandom_range(0, 32'hFFFF);
		endcase
		return r;
	endfunction

	task automatic queue_req(input op_t op, input logic [HUE_W-1:0] h,
			input logic [CHAN_W-1:0] s, input logic [CHAN_W-1:0] v,
			input logic [FORCE_W-1:0] fm);
		color_req_t r;
		r = '{op, h, s, v, fm};
		pending_reqs.insert(pending_reqs.size(), r);
		results_owed++;
	endtask

	task automatic check_channel(input string name, input logic [COLOR_W-1:0] want,
			input logic [COLOR_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic apb_xfer(input logic wr, input logic [2:0] addr,
			input logic [31:0] data, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (wr && addr == FULL_SCALE_ADDR)
			full_scale_model = data;
	endtask

	task automatic set_full_scale(input logic [FORCE_W-1:0] value);
		logic [31:0] rd;
		apb_xfer(1'b1, FULL_SCALE_ADDR, value, rd);
		apb_xfer(1'b0, FULL_SCALE_ADDR, '0, rd);
		if (rd !== value) begin
			$display("%0t: full scale readback expected %0h, got %0h", $time, value, rd);
			mismatches++;
		end
	endtask

	task automatic wait_results();
		do @(posedge clk); while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Request driver: hold each request until taken, then idle a random gap
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			tx_next_valid = req_valid;
			if (req_valid && req_ready) begin
				expected_colors.insert(expected_colors.size(), predict_color(cur_req));
				tx_next_valid = 1'b0;
				tx_gap = tx_quiet ? 0 : $urandom_range(0, 19);
			end
			if (!tx_next_valid) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					operation       <= cur_req.op;
					hue             <= cur_req.hue;
					saturation      <= cur_req.sat;
					brightness      <= cur_req.val;
					force_magnitude <= cur_req.force_mag;
					tx_next_valid = 1'b1;
				end
			end
			req_valid <= tx_next_valid;
		end
	end

	// Result monitor: check in order, then stall a random number of cycles
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_colors.size() == 0) begin
					$display("%0t: expected nothing, got %0d %0d %0d",
						$time, red, green, blue);
					mismatches++;
				end else begin
					want_color = expected_colors.pop_front();
					check_channel("red", want_color.red, red);
					check_channel("green", want_color.green, green);
					check_channel("blue", want_color.blue, blue);
					results_owed--;
				end
				rx_wait = rx_quiet ? 0 : $urandom_range(0, 19);
			end
			if (hold_off_seen != hold_off_count) begin
				hold_off_seen = hold_off_count;
				rx_wait = HOLD_OFF_CYCLES;
			end
			if (rx_wait != 0) begin
				rx_wait--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [FORCE_W-1:0] scale;
		logic [31:0]        rd;
		int                 n_items;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sector edges, saturation/value extremes, heat around full scale
		queue_req(OP_HSV, 16'd0,     ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd65535, ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd10922, ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd10923, ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd21845, ONE_Q16, 17'd40000, $urandom);
		queue_req(OP_HSV, 16'd21846, 17'd30000, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd32768, ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd43690, 17'd50000, 17'd50000, $urandom);
		queue_req(OP_HSV, 16'd43691, ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd54613, ONE_Q16, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd54614, 17'd1, 17'd65535, $urandom);
		queue_req(OP_HSV, 16'd12345, 17'd0, ONE_Q16, $urandom);
		queue_req(OP_HSV, 16'd23456, ONE_Q16, 17'd0, $urandom);
		queue_req(OP_HSV, 16'd34567, 17'h1FFFF, 17'h1FFFF, $urandom);
		queue_req(OP_HSV, 16'd45678, 17'd65537, 17'd98304, $urandom);
		queue_req(OP_HEAT, HUE_W'($urandom), rand_chan(), rand_chan(), 32'd0);
		queue_req(OP_HEAT, HUE_W'($urandom), rand_chan(), rand_chan(), 32'd32768);
		queue_req(OP_HEAT, HUE_W'($urandom), rand_chan(), rand_chan(), 32'd65535);
		queue_req(OP_HEAT, HUE_W'($urandom), rand_chan(), rand_chan(), 32'd65536);
		queue_req(OP_HEAT, HUE_W'($urandom), rand_chan(), rand_chan(), 32'hFFFF_FFFF);
		wait_results();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: scale = 32'd1;
				1: scale = 32'hFFFF_FFFF;
				2: scale = 32'd100 << 16;
				3: scale = 32'd0;
				4: scale = $urandom;
				default: scale = FULL_SCALE_RST;
			endcase
			set_full_scale(scale);
			// a write past the last register must leave the full scale alone
			if (phase == 3)
				apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);
			tx_quiet = (phase == 2) || ($urandom_range(0, 2) == 0);
			rx_quiet = ($urandom_range(0, 2) == 0);
			n_items = (phase == 2) ? 80 : 55;
			for (int i = 0; i < n_items; i++)
				pending_reqs.insert(pending_reqs.size(), rand_req(scale));
			results_owed += n_items;
			// choke the result side so the pipeline backs up into req_ready
			if (phase == 2)
				hold_off_count++;
			wait_results();
		end

		if (mismatches == 0)
			$display("tb_hsv_heat_map_color passed");
		else
			$display("tb_hsv_heat_map_color failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_hsv_heat_map_color failed");
		$finish;
	end

endmodule
